FILE: hw/rtl/sce_pkg.sv
package sce_pkg;

    localparam int CNT_W      = 7;
    localparam int LABEL_W    = 6;
    localparam int LOGIT_W    = 16;
    localparam int PROB_W     = 16;
    localparam int GRAD_W     = 16;
    localparam int BATCH_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int E_W        = 31;   // exp value, Q30 up to 1.0
    localparam int Y_W        = 33;   // d * log2(e)
    localparam int Z_W        = 30;   // f * ln2, Q30
    localparam int K_W        = 3;    // series term counter
    localparam int RECIP_W    = 32;
    localparam int Q_W        = 17;   // quotient bits of the serial divider

    localparam logic [16:0]        LOG2E_Q16 = 17'd94548;
    localparam logic [Z_W-1:0]     LN2_Q30   = 30'd744261118;
    localparam logic [E_W-1:0]     ONE_Q30   = 31'h4000_0000;
    localparam logic [K_W-1:0]     K_FIRST   = 3'd6;
    localparam logic [K_W-1:0]     K_LAST    = 3'd1;

    localparam logic [CNT_W-1:0]   ROW_LENGTH_RST = 7'd16;
    localparam logic [BATCH_W-1:0] BATCH_SIZE_RST = 16'd1;

    typedef enum logic
    {
        CFG_ROW_LENGTH = 1'b0,
        CFG_BATCH_SIZE = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic signed [LOGIT_W-1:0] logit;
        logic [LABEL_W-1:0]        label;
    } item_t;

    typedef struct packed
    {
        logic [PROB_W-1:0]        probability;
        logic signed [GRAD_W-1:0] gradient;
        logic [LABEL_W-1:0]       class_index;
        logic                     row_last;
    } result_t;

    typedef struct packed
    {
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic sum_clr;
        logic max_upd;
        logic exp_start;
        logic e_write;
        logic div_p_start;
        logic p_latch;
        logic div_g_start;
        logic g_latch;
        logic emit;
    } sce_cmd_t;

    typedef struct packed
    {
        logic row_done;
        logic idx_last;
        logic exp_done;
        logic div_done;
        logic out_free;
    } sce_stat_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_MAX_RD,
        ST_MAX_CMP,
        ST_EXP_RD,
        ST_EXP_GO,
        ST_EXP_WAIT,
        ST_P_RD,
        ST_P_GO,
        ST_P_WAIT,
        ST_G_GO,
        ST_G_WAIT,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0]
    {
        EX_IDLE,
        EX_FRAC,
        EX_MUL,
        EX_RECIP,
        EX_CORR,
        EX_OUT
    } exp_state_t;

    // floor((2^32 - 1) / k): undershoots the true quotient by at most one
    function automatic logic [RECIP_W-1:0] recip(input logic [K_W-1:0] k);
        logic [RECIP_W-1:0] m;
        case (k)
            3'd1:    m = 32'hFFFF_FFFF;
            3'd2:    m = 32'h7FFF_FFFF;
            3'd3:    m = 32'h5555_5555;
            3'd4:    m = 32'h3FFF_FFFF;
            3'd5:    m = 32'h3333_3333;
            3'd6:    m = 32'h2AAA_AAAA;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

FILE: hw/rtl/softmax_cross_entropy_grad.sv
// Channel  Dir  Handshake                    Word
// item     in   item_valid / item_ready      logit Q8.8, label
// result   out  result_valid / result_ready  probability, gradient, class_index, row_last
// config   in   cfg_we (no wait)             cfg_index, cfg_data
//
// A logit word is taken whenever the controller is idle; the row's last word
// starts the row run. Row run per class: max pass, exp pass (six-term series,
// multiply, reciprocal and correction states a term), output pass (two 17-step
// divides, one emit); result stalls lengthen the run, no words taken meanwhile.
// Reset is asynchronous, active low; no clearing pass on the logit store.
// Result register holds a word while result_ready is low; the row run stalls
// only when the next result finds it still full.
module softmax_cross_entropy_grad #(
    parameter int MAX_CLASSES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  sce_pkg::item_t                 item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output sce_pkg::result_t               result,
    input  logic                           cfg_we,
    input  sce_pkg::cfg_index_t            cfg_index,
    input  logic [sce_pkg::CFG_DATA_W-1:0] cfg_data
);

    // controller sequences the passes; datapath holds store, exp unit and divider
    sce_pkg::sce_cmd_t  cmd;
    sce_pkg::sce_stat_t stat;

    sce_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    sce_datapath #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: hw/rtl/sce_ram.sv
module sce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/sce_div.sv
module sce_div #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 37,
    parameter int QW    = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QW-1:0]    quot,
    output logic             done
);

    // restoring divider, one quotient bit a cycle; caller keeps num / den < 2^QW
    localparam int CW = $clog2(QW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, q_reg[QW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = DEN_W'(num[NUM_W-1:QW]);
            q_next    = num[QW-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            q_next   = {q_reg[QW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

FILE: hw/rtl/sce_exp.sv
module sce_exp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [15:0]             d,
    output logic [sce_pkg::E_W-1:0] e,
    output logic                    done
);

    // exp(-d) in Q30: split into 2^-n * 2^-f, 2^-f by a six-term series
    localparam int E_W = sce_pkg::E_W;
    localparam int Z_W = sce_pkg::Z_W;
    localparam int K_W = sce_pkg::K_W;

    sce_pkg::exp_state_t state_reg, state_next;

    logic ld_y, ld_z, ld_v, ld_q, ld_t, k_dec;

    logic [sce_pkg::Y_W-1:0] y_reg;
    logic [Z_W-1:0]          z_reg;
    logic [4:0]              n_reg;
    logic                    zero_reg;
    logic [E_W-1:0]          t_reg, v_reg, q0_reg;
    logic [K_W-1:0]          k_reg;

    logic [32:0]  y_prod;
    logic [45:0]  z_prod;
    logic [60:0]  v_prod;
    logic [62:0]  q_prod;
    logic [8:0]   n_full;
    logic [E_W-1:0] qk, r, q_fix;

    assign y_prod = {17'd0, d} * {16'd0, sce_pkg::LOG2E_Q16};
    assign n_full = y_reg[32:24];
    assign z_prod = {30'd0, y_reg[23:8]} * {16'd0, sce_pkg::LN2_Q30};
    assign v_prod = {31'd0, z_reg} * {30'd0, t_reg};
    assign q_prod = {32'd0, v_reg} * {31'd0, sce_pkg::recip(k_reg)};
    assign qk     = q0_reg * E_W'(k_reg);
    assign r      = v_reg - qk;
    assign q_fix  = (r >= E_W'(k_reg)) ? q0_reg + 1'b1 : q0_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sce_pkg::EX_IDLE:  if (start) state_next = sce_pkg::EX_FRAC;
            sce_pkg::EX_FRAC:  state_next = sce_pkg::EX_MUL;
            sce_pkg::EX_MUL:   state_next = sce_pkg::EX_RECIP;
            sce_pkg::EX_RECIP: state_next = sce_pkg::EX_CORR;
            sce_pkg::EX_CORR:
                state_next = (k_reg == sce_pkg::K_LAST) ? sce_pkg::EX_OUT : sce_pkg::EX_MUL;
            sce_pkg::EX_OUT:   state_next = sce_pkg::EX_IDLE;
            default:           state_next = sce_pkg::EX_IDLE;
        endcase
    end

    always_comb
    begin
        ld_y  = 1'b0;
        ld_z  = 1'b0;
        ld_v  = 1'b0;
        ld_q  = 1'b0;
        ld_t  = 1'b0;
        k_dec = 1'b0;
        done  = 1'b0;
        case (state_reg)
            sce_pkg::EX_IDLE:  ld_y = start;
            sce_pkg::EX_FRAC:  ld_z = 1'b1;
            sce_pkg::EX_MUL:   ld_v = 1'b1;
            sce_pkg::EX_RECIP: ld_q = 1'b1;
            sce_pkg::EX_CORR:
            begin
                ld_t  = 1'b1;
                k_dec = 1'b1;
            end
            sce_pkg::EX_OUT:   done = 1'b1;
            default:           done = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sce_pkg::EX_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_y)
        begin
            y_reg <= y_prod;
        end
        if (ld_z)
        begin
            z_reg    <= z_prod[45:16];
            n_reg    <= n_full[4:0];
            zero_reg <= n_full >= 9'd31;
            t_reg    <= sce_pkg::ONE_Q30;
            k_reg    <= sce_pkg::K_FIRST;
        end
        if (ld_v)
        begin
            v_reg <= v_prod[60:30];
        end
        if (ld_q)
        begin
            q0_reg <= q_prod[62:32];
        end
        if (ld_t)
        begin
            t_reg <= sce_pkg::ONE_Q30 - q_fix;
        end
        if (k_dec)
        begin
            k_reg <= k_reg - 1'b1;
        end
    end

    assign e = zero_reg ? '0 : (t_reg >> n_reg);

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == sce_pkg::EX_IDLE)
        else $error("exp unit started while busy");

endmodule

FILE: hw/rtl/sce_ctrl.sv
module sce_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  sce_pkg::sce_stat_t stat,
    output sce_pkg::sce_cmd_t  cmd
);

    sce_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sce_pkg::ST_IDLE:
                if (item_valid && stat.row_done) state_next = sce_pkg::ST_MAX_RD;
            sce_pkg::ST_MAX_RD:  state_next = sce_pkg::ST_MAX_CMP;
            sce_pkg::ST_MAX_CMP:
                state_next = stat.idx_last ? sce_pkg::ST_EXP_RD : sce_pkg::ST_MAX_RD;
            sce_pkg::ST_EXP_RD:  state_next = sce_pkg::ST_EXP_GO;
            sce_pkg::ST_EXP_GO:  state_next = sce_pkg::ST_EXP_WAIT;
            sce_pkg::ST_EXP_WAIT:
                if (stat.exp_done)
                    state_next = stat.idx_last ? sce_pkg::ST_P_RD : sce_pkg::ST_EXP_RD;
            sce_pkg::ST_P_RD:    state_next = sce_pkg::ST_P_GO;
            sce_pkg::ST_P_GO:    state_next = sce_pkg::ST_P_WAIT;
            sce_pkg::ST_P_WAIT:
                if (stat.div_done) state_next = sce_pkg::ST_G_GO;
            sce_pkg::ST_G_GO:    state_next = sce_pkg::ST_G_WAIT;
            sce_pkg::ST_G_WAIT:
                if (stat.div_done) state_next = sce_pkg::ST_EMIT;
            sce_pkg::ST_EMIT:
                if (stat.out_free)
                    state_next = stat.idx_last ? sce_pkg::ST_IDLE : sce_pkg::ST_P_RD;
            default:             state_next = sce_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            sce_pkg::ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.load    = item_valid;
                cmd.idx_clr = item_valid && stat.row_done;
            end
            sce_pkg::ST_MAX_CMP:
            begin
                cmd.max_upd = 1'b1;
                cmd.idx_clr = stat.idx_last;
                cmd.sum_clr = stat.idx_last;
                cmd.idx_inc = !stat.idx_last;
            end
            sce_pkg::ST_EXP_GO:  cmd.exp_start = 1'b1;
            sce_pkg::ST_EXP_WAIT:
            begin
                cmd.e_write = stat.exp_done;
                cmd.idx_clr = stat.exp_done && stat.idx_last;
                cmd.idx_inc = stat.exp_done && !stat.idx_last;
            end
            sce_pkg::ST_P_GO:    cmd.div_p_start = 1'b1;
            sce_pkg::ST_P_WAIT:  cmd.p_latch = stat.div_done;
            sce_pkg::ST_G_GO:    cmd.div_g_start = 1'b1;
            sce_pkg::ST_G_WAIT:  cmd.g_latch = stat.div_done;
            sce_pkg::ST_EMIT:
            begin
                cmd.emit    = stat.out_free;
                cmd.idx_clr = stat.out_free && stat.idx_last;
                cmd.idx_inc = stat.out_free && !stat.idx_last;
            end
            default:             cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sce_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/sce_datapath.sv
module sce_datapath #(
    parameter int MAX_CLASSES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sce_pkg::sce_cmd_t              cmd,
    output sce_pkg::sce_stat_t             stat,
    input  sce_pkg::item_t                 item,
    input  logic                           cfg_we,
    input  sce_pkg::cfg_index_t            cfg_index,
    input  logic [sce_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           result_valid,
    input  logic                           result_ready,
    output sce_pkg::result_t               result
);

    localparam int AW    = $clog2(MAX_CLASSES);
    localparam int CNT_W = sce_pkg::CNT_W;
    localparam int E_W   = sce_pkg::E_W;
    localparam int SUM_W = E_W + $clog2(MAX_CLASSES);
    localparam int NUM_W = E_W + sce_pkg::PROB_W;
    localparam int QW    = sce_pkg::Q_W;
    localparam int BW    = sce_pkg::BATCH_W;

    // configuration
    logic [CNT_W-1:0] row_length_reg, row_length_next;
    logic [BW-1:0]    batch_size_reg, batch_size_next;
    logic [CNT_W-1:0] len_eff;
    logic [BW-1:0]    batch_eff;

    // row control
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [sce_pkg::LABEL_W-1:0] label_reg, label_next;
    logic [AW-1:0]              idx_reg, idx_next;

    // datapath registers
    logic signed [15:0]           mx_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic [15:0]                  p_reg;
    logic signed [15:0]           g_reg;
    logic                         out_valid_reg, out_valid_next;
    sce_pkg::result_t             result_reg;

    logic [15:0]      logit_rd;
    logic [E_W-1:0]   e_rd, e_val;
    logic [16:0]      diff;
    logic             hit, exp_done, div_done, div_start;
    logic [NUM_W-1:0] div_num, num_p;
    logic [SUM_W-1:0] div_den;
    logic [QW-1:0]    div_q;
    logic [16:0]      gmag, gnum, gden;
    logic signed [15:0] g_val;

    always_comb
    begin
        if (row_length_reg == '0)
            len_eff = CNT_W'(1);
        else if (row_length_reg > CNT_W'(MAX_CLASSES))
            len_eff = CNT_W'(MAX_CLASSES);
        else
            len_eff = row_length_reg;
    end

    assign batch_eff = (batch_size_reg == '0) ? BW'(1) : batch_size_reg;

    always_comb
    begin
        row_length_next = row_length_reg;
        batch_size_next = batch_size_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                sce_pkg::CFG_ROW_LENGTH: row_length_next = cfg_data[CNT_W-1:0];
                sce_pkg::CFG_BATCH_SIZE: batch_size_next = cfg_data[BW-1:0];
                default:                 row_length_next = row_length_reg;
            endcase
        end
    end

    assign stat.row_done = (count_reg + 1'b1) >= len_eff;
    assign stat.idx_last = CNT_W'(idx_reg) == (len_eff - 1'b1);
    assign stat.exp_done = exp_done;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        count_next = count_reg;
        label_next = label_reg;
        if (cmd.load)
        begin
            count_next = stat.row_done ? '0 : count_reg + 1'b1;
            label_next = item.label;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    sce_ram #(
        .WIDTH (16),
        .DEPTH (MAX_CLASSES)
    ) u_logit_ram (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (count_reg[AW-1:0]),
        .wdata (item.logit),
        .raddr (idx_reg),
        .rdata (logit_rd)
    );

    sce_ram #(
        .WIDTH (E_W),
        .DEPTH (MAX_CLASSES)
    ) u_exp_ram (
        .clk   (clk),
        .we    (cmd.e_write),
        .waddr (idx_reg),
        .wdata (e_val),
        .raddr (idx_reg),
        .rdata (e_rd)
    );

    // max - x is never negative once the max pass is done
    assign diff = {mx_reg[15], mx_reg} - {logit_rd[15], logit_rd};

    sce_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.exp_start),
        .d     (diff[15:0]),
        .e     (e_val),
        .done  (exp_done)
    );

    assign hit   = CNT_W'(idx_reg) == CNT_W'(label_reg);
    assign num_p = {e_rd, 16'd0} + NUM_W'(sum_reg >> 1);
    assign gmag  = hit ? (17'h1_0000 - {1'b0, p_reg}) : {1'b0, p_reg};
    assign gnum  = gmag + {1'b0, batch_eff};
    assign gden  = {batch_eff, 1'b0};

    assign div_start = cmd.div_p_start || cmd.div_g_start;
    assign div_num   = cmd.div_p_start ? num_p : NUM_W'(gnum);
    assign div_den   = cmd.div_p_start ? sum_reg : SUM_W'(gden);

    sce_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W),
        .QW    (QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_q),
        .done  (div_done)
    );

    // sign and saturate the rounded gradient magnitude
    always_comb
    begin
        if (hit)
            g_val = (div_q > 17'd32768) ? 16'sh8000 : $signed(16'd0 - div_q[15:0]);
        else
            g_val = (div_q > 17'd32767) ? 16'sh7FFF : $signed(div_q[15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= sce_pkg::ROW_LENGTH_RST;
            batch_size_reg <= sce_pkg::BATCH_SIZE_RST;
            count_reg      <= '0;
            label_reg      <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            row_length_reg <= row_length_next;
            batch_size_reg <= batch_size_next;
            count_reg      <= count_next;
            label_reg      <= label_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.max_upd && (idx_reg == '0 || $signed(logit_rd) > mx_reg))
        begin
            mx_reg <= $signed(logit_rd);
        end
        if (cmd.sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (cmd.e_write)
        begin
            sum_reg <= sum_reg + SUM_W'(e_val);
        end
        if (cmd.p_latch)
        begin
            p_reg <= div_q[16] ? 16'hFFFF : div_q[15:0];
        end
        if (cmd.g_latch)
        begin
            g_reg <= g_val;
        end
        if (cmd.emit)
        begin
            result_reg.probability <= p_reg;
            result_reg.gradient    <= g_reg;
            result_reg.class_index <= sce_pkg::LABEL_W'(idx_reg);
            result_reg.row_last    <= stat.idx_last;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || result_ready))
        else $error("result overwritten before taken");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(MAX_CLASSES))
        else $error("element count beyond store");

    a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.p_latch |-> div_q <= 17'h1_0000)
        else $error("probability quotient out of range");

endmodule

FILE: tb/sce_checker.sv
`timescale 1ns / 100ps

// Watches item, result and config channels; predicts every row's results and
// compares them with what the block emits.
module sce_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic                           item_ready,
    input  sce_pkg::item_t                 item,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  sce_pkg::result_t               result,
    input  logic                           cfg_we,
    input  sce_pkg::cfg_index_t            cfg_index,
    input  logic [sce_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);

    logic signed [sce_pkg::LOGIT_W-1:0] logit_mem [64];
    logic [sce_pkg::CNT_W-1:0]   elem_cnt;
    logic [sce_pkg::LABEL_W-1:0] cur_label;
    logic [sce_pkg::CNT_W-1:0]   len_reg;
    logic [sce_pkg::BATCH_W-1:0] batch_reg;
    sce_pkg::result_t            expected_words [$];
    int                          mismatches;

    assign pending = expected_words.size();

    // exp(-d) in Q30, d in Q8.8
    function automatic logic [63:0] exp_neg(input logic [31:0] d);
        logic [63:0] y, n, f, z, t;
        int k;
        y = 64'(d) * 64'd94548;
        n = y >> 24;
        f = (y >> 8) & 64'hFFFF;
        if (n >= 31)
            return 64'd0;
        z = (f * 64'd744261118) >> 16;
        t = 64'd1 << 30;
        for (k = 6; k >= 1; k--)
            t = (64'd1 << 30) - ((z * t) >> 30) / 64'(k);
        return t >> n;
    endfunction

    function automatic void predict_row(input int len);
        logic [63:0] e [64];
        logic [63:0] sum, p, mag, den;
        longint g, q;
        int mx, j;
        sce_pkg::result_t w;
        mx = logit_mem[0];
        for (j = 1; j < len; j++)
            if (int'(logit_mem[j]) > mx)
                mx = logit_mem[j];
        sum = 0;
        for (j = 0; j < len; j++)
        begin
            e[j] = exp_neg(32'(mx - int'(logit_mem[j])));
            sum += e[j];
        end
        if (sum == 0)
            sum = 1;
        den = 2 * ((batch_reg == 0) ? 64'd1 : 64'(batch_reg));
        for (j = 0; j < len; j++)
        begin
            p = (e[j] * 64'd65536 + sum / 2) / sum;
            if (p > 65535)
                p = 65535;
            g = longint'(p) - ((j == cur_label) ? 65536 : 0);
            mag = (g < 0) ? 64'(-g) : 64'(g);
            q = longint'((mag + den / 2) / den);
            if (g < 0)
                q = -q;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            w.probability = p[15:0];
            w.gradient    = q[15:0];
            w.class_index = j[5:0];
            w.row_last    = (j + 1 == len);
            expected_words.push_back(w);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int len;
        sce_pkg::result_t exp_w;
        if (!rst_n)
        begin
            elem_cnt   = '0;
            cur_label  = '0;
            len_reg    = sce_pkg::ROW_LENGTH_RST;
            batch_reg  = sce_pkg::BATCH_SIZE_RST;
            fail_count <= 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == sce_pkg::CFG_ROW_LENGTH)
                    len_reg = cfg_data[sce_pkg::CNT_W-1:0];
                else
                    batch_reg = cfg_data;
            end
            if (item_valid && item_ready)
            begin
                len = (len_reg == 0) ? 1 : (len_reg > 64) ? 64 : len_reg;
                logit_mem[elem_cnt[5:0]] = item.logit;
                cur_label = item.label;
                elem_cnt = elem_cnt + 1'b1;
                if (elem_cnt >= len)
                begin
                    elem_cnt = '0;
                    predict_row(len);
                end
            end
            if (result_valid && result_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %p", result);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (result !== exp_w)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, got %p", exp_w, result);
                    end
                end
            end
            fail_count <= mismatches;
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict; prediction and checking sit in sce_checker.
module tb;

    localparam int WATCHDOG_LIMIT = 20000;  // idle cycles, well over a 64-class row run
    localparam int HOLD_CYCLES    = 3000;   // long receiver stall

    logic                           clk;
    logic                           rst_n;
    logic                           item_valid;
    logic                           item_ready;
    sce_pkg::item_t                 item;
    logic                           result_valid;
    logic                           result_ready;
    sce_pkg::result_t               result;
    logic                           cfg_we;
    sce_pkg::cfg_index_t            cfg_index;
    logic [sce_pkg::CFG_DATA_W-1:0] cfg_data;
    int         fail_count;
    int         pending;

    logic       no_idle;    // phases without gaps on either side
    int         hold_req;   // count of long receiver stalls asked for
    int         words_sent;
    int         quiet_cycles = 0;

    softmax_cross_entropy_grad dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    sce_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[softmax_cross_entropy_grad] ERROR");
            $finish;
        end
    end

    // receiver: random stall before each word, one long hold-off on request
    initial
    begin
        int w, hold_seen;
        result_ready = 1'b0;
        hold_seen    = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            w = no_idle ? 0 : $urandom_range(0, 13);
            if (w > 0)
            begin
                result_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    // one logit word; valid stays up straight into the next word when no gap
    task automatic send_logit(input logic [15:0] lg, input logic [5:0] lb);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item.logit <= lg;
        item.label <= lb;
        do @(posedge clk); while (!item_ready);
        words_sent++;
    endtask

    task automatic write_reg(input sce_pkg::cfg_index_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // drop valid, drain every expected word, then let a partial row settle
    task automatic drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (100) @(posedge clk);
    endtask

    initial
    begin
        int i, r, len, len_eff, rows, phase, base;
        logic [15:0] lg;
        logic [5:0]  lb;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_we       = 1'b0;
        cfg_index    = sce_pkg::CFG_ROW_LENGTH;
        cfg_data     = '0;
        no_idle      = 1'b0;
        hold_req     = 0;
        words_sent   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 16 classes, batch 1; field extremes, label 3
        for (i = 0; i < 16; i++)
        begin
            case (i)
                0:       lg = 16'h7FFF;
                1:       lg = 16'h8000;
                2:       lg = 16'h0000;
                3:       lg = 16'hFFFF;
                4:       lg = 16'h7F00;
                default: lg = 16'(i * 1234);
            endcase
            send_logit(lg, 6'd3);
        end
        drain();

        // label beyond row, tied maxima, largest batch
        write_reg(sce_pkg::CFG_ROW_LENGTH, 16'd3);
        write_reg(sce_pkg::CFG_BATCH_SIZE, 16'hFFFF);
        send_logit(16'h0100, 6'd5);
        send_logit(16'h0100, 6'd5);
        send_logit(16'h0080, 6'd63);
        drain();

        // zero row length acts as one, zero batch acts as one
        write_reg(sce_pkg::CFG_ROW_LENGTH, 16'd0);
        write_reg(sce_pkg::CFG_BATCH_SIZE, 16'd0);
        send_logit(16'h1234, 6'd0);
        send_logit(16'h8000, 6'd63);
        drain();

        // row length shortened mid-row: next word flushes the first two entries
        write_reg(sce_pkg::CFG_ROW_LENGTH, 16'd8);
        write_reg(sce_pkg::CFG_BATCH_SIZE, 16'd1);
        for (i = 0; i < 4; i++)
            send_logit(16'(i * 300), 6'(i));
        drain();
        write_reg(sce_pkg::CFG_ROW_LENGTH, 16'd2);
        send_logit(16'h0200, 6'd1);
        drain();

        // random phases
        phase = 0;
        while (words_sent < 300)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                len = 64;
            else if (r < 12)
                len = 127;
            else if (r < 16)
                len = 0;
            else
                len = $urandom_range(1, 8);
            len_eff = (len == 0) ? 1 : (len > 64) ? 64 : len;
            write_reg(sce_pkg::CFG_ROW_LENGTH, 16'(len));
            r = $urandom_range(0, 9);
            write_reg(sce_pkg::CFG_BATCH_SIZE,
                      (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'd0 :
                      (r < 6) ? 16'($urandom_range(1, 16)) : 16'($urandom));
            rows = (len_eff > 8) ? 1 : $urandom_range(1, 6);
            no_idle <= (phase % 4 == 2);
            // one phase stalls the receiver long enough to back up the input
            if (phase == 3)
            begin
                write_reg(sce_pkg::CFG_ROW_LENGTH, 16'd4);
                len_eff = 4;
                rows = 6;
                hold_req <= hold_req + 1;
            end
            repeat (rows)
            begin
                base = $urandom_range(0, 65535);
                lb = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, len_eff - 1));
                for (i = 0; i < len_eff; i++)
                begin
                    // mostly close logits so that several classes carry weight
                    if ($urandom_range(0, 3) == 0)
                        lg = 16'($urandom);
                    else
                        lg = 16'(base + $urandom_range(0, 2047));
                    send_logit(lg, lb);
                end
            end
            drain();
            phase++;
        end

        drain();
        repeat (500) @(posedge clk);
        if (fail_count == 0)
            $display("[softmax_cross_entropy_grad] OK");
        else
            $display("[softmax_cross_entropy_grad] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/sce_pkg.sv
hw/rtl/sce_ram.sv
hw/rtl/sce_div.sv
hw/rtl/sce_exp.sv
hw/rtl/sce_ctrl.sv
hw/rtl/sce_datapath.sv
hw/rtl/softmax_cross_entropy_grad.sv
tb/sce_checker.sv
tb/tb.sv
